FILE: design/bgnc_pkg.sv
// Package for the binary grid neighbour count pass unit.
// Holds grid geometry, counter widths, register indexes and the cell rule.
// No dependencies.
`default_nettype none

package bgnc_pkg;

  localparam int unsigned GRID_WIDTH  = 128;
  localparam int unsigned GRID_HEIGHT = 128;
  localparam int unsigned ROW_BYTES   = GRID_WIDTH / 8;

  localparam int unsigned ROW_W = $clog2(GRID_HEIGHT + 1);
  localparam int unsigned COL_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

  localparam int unsigned CELLS_W  = 8;
  localparam int unsigned OROW_W   = 7;
  localparam int unsigned OCOL_W   = 4;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned LINE_W   = 2 * CELLS_W;
  localparam int unsigned ODATA_W  = ((CELLS_W + OROW_W + OCOL_W + 7) / 8) * 8;

  localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(GRID_HEIGHT - 1);
  localparam logic [ROW_W-1:0] FLUSH_ROW  = ROW_W'(GRID_HEIGHT);
  localparam logic [COL_W-1:0] LAST_COL   = COL_W'(ROW_BYTES - 1);
  localparam logic [COUNT_W-1:0] MIN_RESET = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] MAX_RESET = COUNT_W'(8);

  typedef enum logic [0:0] {
    REG_MIN_LIVE = 1'b0,
    REG_MAX_LIVE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CELLS_W-1:0] top;
    logic [CELLS_W-1:0] mid;
    logic [CELLS_W-1:0] bot;
  } col_t;

  // Each row vector is {left byte bit 0, centre byte, right byte bit 7}.
  function automatic logic [CELLS_W-1:0] smooth_byte(
    input logic [CELLS_W+1:0] top,
    input logic [CELLS_W+1:0] mid,
    input logic [CELLS_W+1:0] bot,
    input logic [COUNT_W-1:0] lo,
    input logic [COUNT_W-1:0] hi
  );
    logic [CELLS_W-1:0] res;
    logic [COUNT_W-1:0] cnt;
    res = '0;
    for (int i = 0; i < CELLS_W; i++) begin
      cnt = COUNT_W'(top[i]) + COUNT_W'(top[i+1]) + COUNT_W'(top[i+2])
          + COUNT_W'(mid[i]) + COUNT_W'(mid[i+2])
          + COUNT_W'(bot[i]) + COUNT_W'(bot[i+1]) + COUNT_W'(bot[i+2]);
      res[i] = (cnt >= lo) && (cnt <= hi);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/bgnc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module bgnc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/binary_grid_neighbor_count_pass_unit.sv
// Top level of the binary grid neighbour count pass unit.
// Depends on bgnc_pkg and bgnc_ram.
`default_nettype none

// One smoothing pass over a GRID_WIDTH x GRID_HEIGHT binary grid fed in raster
// order, eight cells per input byte (bit 7 leftmost). A result cell is live when
// its count of live neighbours lies in [min, max]; cells beyond the edge count
// as live. Input bytes are taken one per cycle unless the result stream stalls;
// a byte that closes a row yields two results and holds the input until its
// second result is issued, and the final byte of the grid holds the input while
// the last row is read back out of the line store. The rate is set by the single
// result register, which takes one result per cycle unless the result stream
// stalls. The line store is one RAM of ROW_BYTES words, each holding the two
// previous rows of one byte column; every input byte reads its word and writes
// it back shifted. A result is held in the event register and then in the result
// register before it is offered. Write the min/max registers only while idle.
module binary_grid_neighbor_count_pass_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire bgnc_pkg::cfg_reg_e               cfg_index_i,
  input  wire logic [bgnc_pkg::COUNT_W-1:0]     cfg_data_i,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [bgnc_pkg::CELLS_W-1:0]     s_axis_tdata,  // in_cells
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // out_cells [7:0], out_row [14:8], out_column [18:15], zero pad
  output logic [bgnc_pkg::ODATA_W-1:0]          m_axis_tdata,
  output logic                                  m_axis_tlast,  // last_of_run
  output logic                                  m_axis_tuser   // frame_done
);

  import bgnc_pkg::*;

  logic [COUNT_W-1:0] min_q, max_q;

  logic [ROW_W-1:0] in_row_q;
  logic [COL_W-1:0] in_col_q;
  logic             flush_q;
  logic [COL_W-1:0] flush_col_q;

  logic             ev_valid_q, ev_a_q, ev_b_q;
  logic [CELLS_W-1:0] ev_byte_q;
  logic [ROW_W-1:0] ev_row_q;
  logic [COL_W-1:0] ev_col_q;
  logic             ev_virt_q, ev_end_q;

  col_t             prev1_q, prev2_q, cur, left;
  logic [LINE_W-1:0] rdata;

  logic             out_valid_q;
  logic [CELLS_W-1:0] out_cells_q;
  logic [OROW_W-1:0] out_row_q;
  logic [OCOL_W-1:0] out_col_q;
  logic             out_last_q, out_done_q;

  logic             s_acc, in_final, load, out_free, emit, emit_a, emit_b;
  logic             s1_done, s1_free, ram_we;
  logic [CELLS_W-1:0] res_a, res_b;
  logic [ROW_W-1:0] row_m1;
  logic [COL_W-1:0] col_m1;
  logic [31:0]      row_ext, col_ext;

  assign cfg_ready_o = 1'b1;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign in_final = (in_row_q == LAST_ROW) && (in_col_q == LAST_COL);
  assign out_free = !out_valid_q || m_axis_tready;
  assign emit     = ev_valid_q && out_free && (ev_a_q || ev_b_q);
  assign emit_a   = emit && ev_a_q;
  assign emit_b   = emit && !ev_a_q;
  assign s1_done  = ev_valid_q && (!(ev_a_q || ev_b_q) || (out_free && !(ev_a_q && ev_b_q)));
  assign s1_free  = !ev_valid_q || s1_done;
  assign s_axis_tready = s1_free && !flush_q;
  assign load     = s1_free && (s_acc || flush_q);
  assign ram_we   = s1_done && !ev_virt_q;

  bgnc_ram #(
    .Width (LINE_W),
    .Depth (ROW_BYTES)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ev_col_q),
    .wdata_i ({rdata[CELLS_W-1:0], ev_byte_q}),
    .re_i    (load),
    .raddr_i (flush_q ? flush_col_q : in_col_q),
    .rdata_o (rdata)
  );

  always_comb begin
    cur.top = (ev_row_q >= ROW_W'(2)) ? rdata[LINE_W-1:CELLS_W] : '1;
    cur.mid = rdata[CELLS_W-1:0];
    cur.bot = ev_byte_q;
    left    = (ev_col_q == COL_W'(1)) ? '1 : prev2_q;
    res_a = smooth_byte({left.top[0], prev1_q.top, cur.top[CELLS_W-1]},
                        {left.mid[0], prev1_q.mid, cur.mid[CELLS_W-1]},
                        {left.bot[0], prev1_q.bot, cur.bot[CELLS_W-1]},
                        min_q, max_q);
    res_b = smooth_byte({prev1_q.top[0], cur.top, 1'b1},
                        {prev1_q.mid[0], cur.mid, 1'b1},
                        {prev1_q.bot[0], cur.bot, 1'b1},
                        min_q, max_q);
    row_m1  = ev_row_q - ROW_W'(1);
    col_m1  = emit_a ? (ev_col_q - COL_W'(1)) : ev_col_q;
    row_ext = 32'(row_m1);
    col_ext = 32'(col_m1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= MIN_RESET;
      max_q       <= MAX_RESET;
      in_row_q    <= '0;
      in_col_q    <= '0;
      flush_q     <= 1'b0;
      flush_col_q <= '0;
      ev_valid_q  <= 1'b0;
      ev_a_q      <= 1'b0;
      ev_b_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_MIN_LIVE: min_q <= cfg_data_i;
          REG_MAX_LIVE: max_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (s_acc) begin
        if (in_col_q == LAST_COL) begin
          in_col_q <= '0;
          in_row_q <= (in_row_q == LAST_ROW) ? '0 : in_row_q + ROW_W'(1);
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
      end

      if (s_acc && in_final) begin
        flush_q     <= 1'b1;
        flush_col_q <= '0;
      end else if (flush_q && s1_free) begin
        flush_q     <= (flush_col_q != LAST_COL);
        flush_col_q <= (flush_col_q == LAST_COL) ? '0 : flush_col_q + COL_W'(1);
      end

      if (load) begin
        ev_valid_q <= 1'b1;
        if (flush_q) begin
          ev_a_q <= (flush_col_q != '0);
          ev_b_q <= (flush_col_q == LAST_COL);
        end else begin
          ev_a_q <= (in_row_q != '0) && (in_col_q != '0);
          ev_b_q <= (in_row_q != '0) && (in_col_q == LAST_COL);
        end
      end else if (s1_done) begin
        ev_valid_q <= 1'b0;
        ev_a_q     <= 1'b0;
        ev_b_q     <= 1'b0;
      end else if (emit_a) begin
        ev_a_q <= 1'b0;
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_virt_q <= flush_q;
      if (flush_q) begin
        ev_byte_q <= '1;
        ev_row_q  <= FLUSH_ROW;
        ev_col_q  <= flush_col_q;
        ev_end_q  <= (flush_col_q == LAST_COL);
      end else begin
        ev_byte_q <= s_axis_tdata;
        ev_row_q  <= in_row_q;
        ev_col_q  <= in_col_q;
        ev_end_q  <= !in_final;
      end
    end
    if (s1_done) begin
      prev2_q <= prev1_q;
      prev1_q <= cur;
    end
    if (emit) begin
      out_cells_q <= emit_a ? res_a : res_b;
      out_row_q   <= row_ext[OROW_W-1:0];
      out_col_q   <= col_ext[OCOL_W-1:0];
      out_last_q  <= ev_end_q && (emit_b || !ev_b_q);
      out_done_q  <= emit_b && ev_virt_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ODATA_W'({out_col_q, out_row_q, out_cells_q});
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_done_q;

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without run end");

  a_final_flushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && in_final |=> flush_q && !s_axis_tready)
    else $error("final byte did not start the flush");

  a_pend_needs_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_a_q || ev_b_q) |-> ev_valid_q)
    else $error("pending result without event");

  a_second_at_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_b |-> ev_col_q == LAST_COL)
    else $error("row end result away from last column");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for binary_grid_neighbor_count_pass_unit: streams about a hundred cell bytes
// under varied neighbour-count limits, predicts every result byte and checks it.
// Depends on bgnc_pkg and the unit's RTL.
module tb_top;
  import bgnc_pkg::*;

  typedef struct packed {
    logic [CELLS_W-1:0] cells;
    logic [OROW_W-1:0]  row;
    logic [OCOL_W-1:0]  col;
    logic               last;
    logic               done;
  } smoothed_t;

  localparam int N_SEG          = 9;
  localparam int HOLD_SEG       = 2;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int SEG_LEN  [N_SEG] = '{24, 10, 10, 10, 8, 8, 10, 10, 10};
  localparam int SEG_MODE [N_SEG] = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
  localparam logic [COUNT_W-1:0] SEG_MIN [N_SEG] = '{6, 0, 3, 8, 15, 0, 4, 2, 6};
  localparam logic [COUNT_W-1:0] SEG_MAX [N_SEG] = '{8, 8, 5, 8, 0, 0, 15, 6, 8};
  localparam logic [CELLS_W-1:0] DIRECTED [24] = '{
    8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h7E, 8'h81,
    8'hF0, 8'h0F, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h18, 8'hC3,
    8'hFF, 8'h00, 8'h01, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h3C};

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  cfg_reg_e           cfg_index_i   = REG_MIN_LIVE;
  logic [COUNT_W-1:0] cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [CELLS_W-1:0] s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ODATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;
  logic               m_axis_tuser;

  logic [CELLS_W-1:0] pending_cells [$];
  smoothed_t          smoothed_q [$];
  smoothed_t          due;
  logic [CELLS_W-1:0] line_buf [3][ROW_BYTES];
  logic [COUNT_W-1:0] min_live = MIN_RESET;
  logic [COUNT_W-1:0] max_live = MAX_RESET;
  int                 in_row = 0;
  int                 in_col = 0;
  int                 tx_idle_pct = 0;
  int                 rx_idle_pct = 0;
  int                 fail_cnt = 0;
  int                 cycle_cnt = 0;
  int                 rx_hold_left = 0;
  logic               rx_hold_req = 1'b0;
  logic               rx_hold_done = 1'b0;

  binary_grid_neighbor_count_pass_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic live_at(int row, int x);
    if (row < 0 || row >= int'(GRID_HEIGHT) || x < 0 || x >= int'(GRID_WIDTH)) begin
      return 1'b1;
    end
    return line_buf[row % 3][x / 8][7 - (x % 8)];
  endfunction

  function automatic smoothed_t smoothed_entry(int row, int col);
    smoothed_t e;
    int        cnt;
    int        x;
    e = '0;
    for (int b = 0; b < 8; b++) begin
      x   = col * 8 + b;
      cnt = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          if (dr != 0 || dc != 0) begin
            cnt += int'(live_at(row + dr, x + dc));
          end
        end
      end
      if (cnt >= int'(min_live) && cnt <= int'(max_live)) begin
        e.cells[7-b] = 1'b1;
      end
    end
    e.row  = OROW_W'(row);
    e.col  = OCOL_W'(col);
    e.done = (row == int'(GRID_HEIGHT) - 1) && (col == int'(ROW_BYTES) - 1);
    return e;
  endfunction

  task automatic take_cells(logic [CELLS_W-1:0] cells);
    smoothed_t batch [ROW_BYTES+2];
    int        n;
    n = 0;
    line_buf[in_row % 3][in_col] = cells;
    if (in_row >= 1) begin
      if (in_col >= 1) begin
        batch[n] = smoothed_entry(in_row - 1, in_col - 1);
        n++;
      end
      if (in_col == int'(ROW_BYTES) - 1) begin
        batch[n] = smoothed_entry(in_row - 1, in_col);
        n++;
      end
    end
    if (in_row == int'(GRID_HEIGHT) - 1 && in_col == int'(ROW_BYTES) - 1) begin
      for (int cc = 0; cc < int'(ROW_BYTES); cc++) begin
        batch[n] = smoothed_entry(in_row, cc);
        n++;
      end
    end
    if (n > 0) begin
      batch[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      smoothed_q.push_back(batch[i]);
    end
    in_col++;
    if (in_col == int'(ROW_BYTES)) begin
      in_col = 0;
      in_row++;
      if (in_row == int'(GRID_HEIGHT)) begin
        in_row = 0;
      end
    end
  endtask

  function automatic logic [CELLS_W-1:0] random_cells();
    case ($urandom_range(5))
      0, 1: return CELLS_W'($urandom);
      2: return CELLS_W'($urandom & $urandom & $urandom);
      3: return CELLS_W'($urandom | $urandom | $urandom);
      4: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [COUNT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_MIN_LIVE) begin
      min_live = val;
    end else begin
      max_live = val;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cells.size() != 0 || s_axis_tvalid || smoothed_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_cells(s_axis_tdata);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cells.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_cells.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (smoothed_q.size() == 0) begin
          $error("unexpected result transaction: tdata %0h", m_axis_tdata);
          fail_cnt++;
        end else begin
          due = smoothed_q.pop_front();
          check_field("out_cells", due.cells, m_axis_tdata[7:0]);
          check_field("out_row", due.row, m_axis_tdata[14:8]);
          check_field("out_column", due.col, m_axis_tdata[18:15]);
          check_field("last_of_run", due.last, m_axis_tlast);
          check_field("frame_done", due.done, m_axis_tuser);
        end
      end
      if (rx_hold_req && !rx_hold_done) begin
        rx_hold_done  <= 1'b1;
        rx_hold_left  <= RX_HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (rx_hold_left > 0) begin
        rx_hold_left  <= rx_hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int s = 0; s < N_SEG; s++) begin
      wait_drained();
      tx_idle_pct = (SEG_MODE[s] == 0) ? 28 : (SEG_MODE[s] == 1) ? 51 : 0;
      rx_idle_pct = (SEG_MODE[s] == 0) ? 51 : (SEG_MODE[s] == 1) ? 28 : 0;
      write_reg(REG_MIN_LIVE, SEG_MIN[s]);
      write_reg(REG_MAX_LIVE, SEG_MAX[s]);
      for (int i = 0; i < SEG_LEN[s]; i++) begin
        pending_cells.push_back((s == 0) ? DIRECTED[i] : random_cells());
      end
      if (s == HOLD_SEG) begin
        rx_hold_req <= 1'b1;
      end
    end
    wait_drained();
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
